FILE: hw/rtl/touch_trimmed_mean_filter_assert.svh
// ----------------------------------------------------------------------------
// touch_trimmed_mean_filter_assert.svh
// assertion macros used by the touch filter checker
// ----------------------------------------------------------------------------
`ifndef TOUCH_TRIMMED_MEAN_FILTER_ASSERT_SVH
`define TOUCH_TRIMMED_MEAN_FILTER_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define TTMF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("touch filter check failed");

// next-cycle implication, ignored while reset is held
`define TTMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("touch filter check failed");

// condition that must hold in the cycle after reset is sampled
`define TTMF_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("touch filter reset check failed");

`endif

FILE: hw/rtl/ttmf_pkg.sv
// ----------------------------------------------------------------------------
// ttmf_pkg
// shared widths, constants and controller/datapath types of the touch filter
// ----------------------------------------------------------------------------
`default_nettype none

package ttmf_pkg;

    // field widths
    localparam int SAMPLE_W  = 12;
    localparam int SCALE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // burst shape
    localparam int SAMPLE_COUNT = 10;
    localparam int DROP_HIGH    = 3;
    localparam int KEEP_COUNT   = 5;
    localparam int CNT_W        = $clog2(SAMPLE_COUNT);
    localparam int PHASE_W      = $clog2(SAMPLE_COUNT);

    // trimmed sum and mean by reciprocal multiply
    localparam int SUM_W      = $clog2(KEEP_COUNT * ((1 << SAMPLE_W) - 1) + 1);
    localparam int MEAN_SH    = SUM_W + $clog2(KEEP_COUNT);
    localparam int MEAN_RECIP = ((1 << MEAN_SH) + KEEP_COUNT - 1) / KEEP_COUNT;
    localparam int RECIP_W    = SUM_W + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;

    // screen conversion: ((4096 - mean) << 8) / scale
    localparam int FRAC_W    = 8;
    localparam int NUM_W     = SAMPLE_W + 1 + FRAC_W;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam logic [SAMPLE_W:0]   FULL_SCALE = (SAMPLE_W + 1)'(1 << SAMPLE_W);
    localparam logic [SAMPLE_W-1:0] MAX_COORD  = '1;

    // register reset values
    localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST  = SAMPLE_W'(100);
    localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST = SAMPLE_W'(4000);
    localparam logic [SCALE_W-1:0]  SCALE_X_RST    = SCALE_W'(2048);
    localparam logic [SCALE_W-1:0]  SCALE_Y_RST    = SCALE_W'(3610);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SCALE_W-1:0]  scale_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT  = 2'd0,
        CFG_HIGH_LIMIT = 2'd1,
        CFG_SCALE_X    = 2'd2,
        CFG_SCALE_Y    = 2'd3
    } cfg_idx_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic sort_step;
        logic sort_odd;
        logic sum;
        logic mul;
        logic div_start;
        logic load_full;
        logic load_early;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fill;
        logic pen_down;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ttmf_div.sv
// ----------------------------------------------------------------------------
// ttmf_div
// restoring divider, one quotient bit per cycle, saturating 12-bit result
// ----------------------------------------------------------------------------
`default_nettype none

module ttmf_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [ttmf_pkg::NUM_W-1:0] numer,
    input  wire ttmf_pkg::scale_t         divisor,
    output ttmf_pkg::sample_t             quotient,
    output logic                          done
);
    import ttmf_pkg::*;

    logic [SCALE_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SCALE_W:0]     trial;
    logic [SCALE_W:0]     diff;

    // one shift-subtract step
    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = numer;
            cnt_next  = DIV_CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[SCALE_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[SCALE_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // step state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // zero divisor or oversize quotient clamps to the top code
    assign quotient = (divisor == '0 || (|quo_reg[NUM_W-1:SAMPLE_W])) ?
                      MAX_COORD : quo_reg[SAMPLE_W-1:0];
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ttmf_datapath.sv
// ----------------------------------------------------------------------------
// ttmf_datapath
// config registers, sample stores, sorting network step, trimmed mean,
// screen dividers and output register
// ----------------------------------------------------------------------------
`default_nettype none

module ttmf_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [ttmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttmf_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire ttmf_pkg::sample_t             s_sample_x,
    input  wire ttmf_pkg::sample_t             s_sample_y,
    input  wire logic                          s_pen_down,
    input  wire ttmf_pkg::dp_cmd_t             cmd,
    output ttmf_pkg::dp_status_t               status,
    output ttmf_pkg::sample_t                  m_raw_x,
    output ttmf_pkg::sample_t                  m_raw_y,
    output ttmf_pkg::sample_t                  m_screen_x,
    output ttmf_pkg::sample_t                  m_screen_y,
    output logic                               m_status
);
    import ttmf_pkg::*;

    sample_t             low_limit_reg, high_limit_reg;
    scale_t              scale_x_reg, scale_y_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    sample_t             x_store_reg [SAMPLE_COUNT];
    sample_t             y_store_reg [SAMPLE_COUNT];
    sample_t             x_sorted [SAMPLE_COUNT];
    sample_t             y_sorted [SAMPLE_COUNT];
    logic [SUM_W-1:0]    sum_x, sum_y;
    logic [SUM_W-1:0]    sum_x_reg, sum_y_reg;
    logic [PROD_W-1:0]   prod_x_reg, prod_y_reg;
    sample_t             mean_x, mean_y;
    logic [SAMPLE_W:0]   diff_x, diff_y;
    logic [NUM_W-1:0]    numer_x, numer_y;
    sample_t             quo_x, quo_y;
    logic                done_x, done_y;
    logic                smp_ok;
    logic                fill;
    sample_t             raw_x_reg, raw_y_reg, screen_x_reg, screen_y_reg;
    logic                status_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= LOW_LIMIT_RST;
            high_limit_reg <= HIGH_LIMIT_RST;
            scale_x_reg    <= SCALE_X_RST;
            scale_y_reg    <= SCALE_Y_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOW_LIMIT: begin
                    low_limit_reg <= cfg_wdata[SAMPLE_W-1:0];
                end
                CFG_HIGH_LIMIT: begin
                    high_limit_reg <= cfg_wdata[SAMPLE_W-1:0];
                end
                CFG_SCALE_X: begin
                    scale_x_reg <= cfg_wdata[SCALE_W-1:0];
                end
                CFG_SCALE_Y: begin
                    scale_y_reg <= cfg_wdata[SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sample window check and burst fill detection
    assign smp_ok = (s_sample_x > low_limit_reg) && (s_sample_x < high_limit_reg) &&
                    (s_sample_y > low_limit_reg) && (s_sample_y < high_limit_reg);
    assign fill   = smp_ok && (count_reg == CNT_W'(SAMPLE_COUNT - 1));

    // pairs held; cleared at the end of every burst
    always_comb begin
        count_next = count_reg;
        if (cmd.accept) begin
            if (fill || !s_pen_down) begin
                count_next = '0;
            end else if (smp_ok) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // one odd-even transposition phase, larger value to the lower slot
    always_comb begin
        x_sorted = x_store_reg;
        y_sorted = y_store_reg;
        for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
            if (i[0] == cmd.sort_odd) begin
                if (x_store_reg[i] < x_store_reg[i+1]) begin
                    x_sorted[i]   = x_store_reg[i+1];
                    x_sorted[i+1] = x_store_reg[i];
                end
                if (y_store_reg[i] < y_store_reg[i+1]) begin
                    y_sorted[i]   = y_store_reg[i+1];
                    y_sorted[i+1] = y_store_reg[i];
                end
            end
        end
    end

    // sample stores: fill on accept, sort in place afterwards
    always_ff @(posedge aclk) begin
        if (cmd.accept && smp_ok) begin
            x_store_reg[count_reg] <= s_sample_x;
            y_store_reg[count_reg] <= s_sample_y;
        end else if (cmd.sort_step) begin
            x_store_reg <= x_sorted;
            y_store_reg <= y_sorted;
        end
    end

    // sum of the kept middle ranks
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int k = 0; k < KEEP_COUNT; k++) begin
            sum_x = sum_x + SUM_W'(x_store_reg[DROP_HIGH + k]);
            sum_y = sum_y + SUM_W'(y_store_reg[DROP_HIGH + k]);
        end
    end

    // sum register, then reciprocal multiply for the mean
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            sum_x_reg <= sum_x;
            sum_y_reg <= sum_y;
        end
        if (cmd.mul) begin
            prod_x_reg <= PROD_W'(sum_x_reg) * PROD_W'(MEAN_RECIP);
            prod_y_reg <= PROD_W'(sum_y_reg) * PROD_W'(MEAN_RECIP);
        end
    end

    assign mean_x  = prod_x_reg[MEAN_SH +: SAMPLE_W];
    assign mean_y  = prod_y_reg[MEAN_SH +: SAMPLE_W];
    assign diff_x  = FULL_SCALE - {1'b0, mean_x};
    assign diff_y  = FULL_SCALE - {1'b0, mean_y};
    assign numer_x = {diff_x, {FRAC_W{1'b0}}};
    assign numer_y = {diff_y, {FRAC_W{1'b0}}};

    // screen coordinate dividers, one per axis
    ttmf_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .numer    (numer_x),
        .divisor  (scale_x_reg),
        .quotient (quo_x),
        .done     (done_x)
    );

    ttmf_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .numer    (numer_y),
        .divisor  (scale_y_reg),
        .quotient (quo_y),
        .done     (done_y)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_full) begin
            raw_x_reg    <= mean_x;
            raw_y_reg    <= mean_y;
            screen_x_reg <= quo_x;
            screen_y_reg <= quo_y;
            status_reg   <= 1'b0;
        end else if (cmd.load_early) begin
            raw_x_reg    <= '0;
            raw_y_reg    <= '0;
            screen_x_reg <= '0;
            screen_y_reg <= '0;
            status_reg   <= 1'b1;
        end
    end

    assign m_raw_x    = raw_x_reg;
    assign m_raw_y    = raw_y_reg;
    assign m_screen_x = screen_x_reg;
    assign m_screen_y = screen_y_reg;
    assign m_status   = status_reg;

    assign status = '{fill: fill, pen_down: s_pen_down, div_done: done_x && done_y};

endmodule

`default_nettype wire

FILE: hw/rtl/ttmf_ctrl.sv
// ----------------------------------------------------------------------------
// ttmf_ctrl
// sequencer for sample intake, sort phases, mean, divide and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module ttmf_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ttmf_pkg::dp_cmd_t         cmd,
    input  wire ttmf_pkg::dp_status_t status
);
    import ttmf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_SUM,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT,
        S_EARLY
    } state_t;

    state_t             state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               m_valid_reg, m_valid_next;
    logic               accept;
    logic               out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cmd            = '0;
        cmd.accept     = accept;
        cmd.sort_odd   = phase_reg[0];
        case (state_reg)
            S_IDLE: begin
                phase_next = '0;
                if (accept) begin
                    if (status.fill) begin
                        state_next = S_SORT;
                    end else if (!status.pen_down) begin
                        state_next = S_EARLY;
                    end
                end
            end
            S_SORT: begin
                cmd.sort_step = 1'b1;
                if (phase_reg == PHASE_W'(SAMPLE_COUNT - 1)) begin
                    phase_next = '0;
                    state_next = S_SUM;
                end else begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV_START;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load_full = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EARLY: begin
                if (out_free) begin
                    cmd.load_early = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (cmd.load_full || cmd.load_early) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/touch_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// touch_trimmed_mean_filter
// usage:
//   s_ channel takes one X/Y conversion pair plus pen state per request.
//   Pairs strictly inside low/high limits are held; the tenth held pair ends a
//   burst with a trimmed mean (three highest and two lowest dropped per axis)
//   and screen coordinates ((4096 - mean) << 8) / scale. A pen-up request that
//   does not fill the burst gives a status 1 result with zero coordinates.
//   m_ channel carries at most one result per input request.
//   A request that yields no result leaves s_ready high, so such requests
//   can follow back to back.
//   Pen-up early result: accept leads to S_EARLY, which sets m_valid once the
//   output is free, s_ready back with it. Completing request: m_valid follows
//   10 sort phases, sum and multiply steps and the 21-step divider (both axes
//   in parallel) and the output load; no new request is taken meanwhile.
//   The result sits in an output register; while the receiver stalls the
//   block still takes requests that give no result and waits with the next.
//   Reset (aresetn low at a clock edge) restores the register defaults and
//   empties the burst; cfg_we writes land at once and belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_trimmed_mean_filter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [ttmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttmf_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ttmf_pkg::sample_t             s_sample_x,
    input  wire ttmf_pkg::sample_t             s_sample_y,
    input  wire logic                          s_pen_down,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ttmf_pkg::sample_t                  m_raw_x,
    output ttmf_pkg::sample_t                  m_raw_y,
    output ttmf_pkg::sample_t                  m_screen_x,
    output ttmf_pkg::sample_t                  m_screen_y,
    output logic                               m_status
);
    import ttmf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    ttmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // storage and arithmetic
    ttmf_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_sample_x (s_sample_x),
        .s_sample_y (s_sample_y),
        .s_pen_down (s_pen_down),
        .cmd        (cmd),
        .status     (status),
        .m_raw_x    (m_raw_x),
        .m_raw_y    (m_raw_y),
        .m_screen_x (m_screen_x),
        .m_screen_y (m_screen_y),
        .m_status   (m_status)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/ttmf_checker.sv
// ----------------------------------------------------------------------------
// ttmf_checker
// port-level checks of the touch filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_trimmed_mean_filter_assert.svh"

module ttmf_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              s_pen_down,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire ttmf_pkg::sample_t m_raw_x,
    input wire ttmf_pkg::sample_t m_raw_y,
    input wire ttmf_pkg::sample_t m_screen_x,
    input wire ttmf_pkg::sample_t m_screen_y,
    input wire logic              m_status
);
    import ttmf_pkg::*;

    // no result pending right after reset
    `TTMF_ASSERT_RESET(a_reset_idle, !m_valid)

    // stalled result holds
    `TTMF_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_raw_x) && $stable(m_raw_y) && $stable(m_screen_x) && $stable(m_screen_y) && $stable(m_status))

    // early release carries zero coordinates
    `TTMF_ASSERT_NOW(a_early_zero, m_valid && m_status, m_raw_x == '0 && m_raw_y == '0 && m_screen_x == '0 && m_screen_y == '0)

    // a pen-up request always ends the burst, so intake pauses
    `TTMF_ASSERT_NEXT(a_penup_busy, s_valid && s_ready && !s_pen_down, !s_ready)

endmodule

bind touch_trimmed_mean_filter ttmf_checker u_checker (.*);

`default_nettype wire
